@@ rtl/core/ipu_pkg.sv @@
// Shared types and constants for the integer pixel upscaler.
// No dependencies; every other file of the block uses this package.
package ipu_pkg;

    localparam int PIX_W       = 24;
    localparam int SCALE_CFG_W = 5;
    localparam int WIDTH_CFG_W = 13;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic OP_PUSH   = 1'b0;
    localparam logic OP_REPLAY = 1'b1;

    localparam logic REG_SCALE     = 1'b0;
    localparam logic REG_ROW_WIDTH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             at_end;
        logic [1:0]       pad;
        logic             drop;
    } pix_cmd_t;

endpackage

@@ rtl/core/integer_pixel_upscaler.sv @@
// Top level of the integer pixel upscaler: configuration registers, front end,
// command queue and back end. Depends on ipu_pkg, ipu_front, ipu_queue, ipu_back.
//
// Channel  Direction  Handshake             Payload
// s_       in         s_tvalid / s_tready   s_tdata pixel, s_tuser opcode
// m_       out        m_tvalid / m_tready   m_tdata pixel, row end and padding, m_tlast, m_tuser
// cfg_     in         cfg_valid / cfg_ready cfg_index register, cfg_data value
//
// Each item gives scale results (one when dropped); the copy counter in the back end sets
// the rate of one result per cycle while the output is not stalled and the queue holds items.
// With an empty queue, an item passes the front stage, queue and output registers in turn.
// Reset clears the row position and phase; the line store needs no clearing.
// A stall on the output fills the queue before the input stops.
module integer_pixel_upscaler #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ipu_pkg::IN_DATA_W-1:0]       s_tdata,   // blue_in, green_in, red_in
    input  logic                                s_tuser,   // opcode
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipu_pkg::OUT_DATA_W-1:0]      m_tdata,   // blue_out, green_out, red_out,
                                                           // row_end, pad_bytes
    output logic                                m_tlast,   // run_last
    output logic                                m_tuser,   // dropped
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [ipu_pkg::WIDTH_CFG_W-1:0]     cfg_data
);

    localparam int SW = $clog2(MAX_SCALE + 1);

    logic [ipu_pkg::SCALE_CFG_W-1:0] scale_reg;
    logic [ipu_pkg::WIDTH_CFG_W-1:0] width_reg;
    logic                            cmd_valid;
    ipu_pkg::pix_cmd_t               cmd;
    ipu_pkg::pix_cmd_t               q_data;
    logic                            q_full;
    logic                            q_empty;
    logic                            q_pop;
    logic [SW-1:0]                   eff_scale;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= ipu_pkg::SCALE_CFG_W'(1);
            width_reg <= ipu_pkg::WIDTH_CFG_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipu_pkg::REG_SCALE:     scale_reg <= cfg_data[ipu_pkg::SCALE_CFG_W-1:0];
                ipu_pkg::REG_ROW_WIDTH: width_reg <= cfg_data;
                default:                width_reg <= width_reg;
            endcase
        end
    end

    ipu_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .scale_cfg (scale_reg),
        .width_cfg (width_reg),
        .q_full    (q_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .eff_scale (eff_scale)
    );

    ipu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .push_data (cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    ipu_back #(
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .eff_scale (eff_scale),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // A dropped item gives a single result that carries no pixel or row end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[26:0] == 27'd0)))
        else $error("dropped result carries data or is not last");

    // A row can only end on the last copy of a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[24]) |-> m_tlast)
        else $error("row end before the last copy");

    // Padding is reported only at a row end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[26:25] != 2'd0)) |-> m_tdata[24])
        else $error("padding away from a row end");

    // While the queue is full, a waiting command holds the front stage and the input is not ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && q_full) |-> !s_tready)
        else $error("front accepted while its stage is blocked");

endmodule

@@ rtl/core/ipu_front.sv @@
// Front end of the upscaler: accepts items, checks the phase, keeps the row
// position and the line store, and hands one command per item to the queue.
// Depends on ipu_pkg.
module ipu_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ipu_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                s_tuser,
    input  logic [ipu_pkg::SCALE_CFG_W-1:0]     scale_cfg,
    input  logic [ipu_pkg::WIDTH_CFG_W-1:0]     width_cfg,
    input  logic                                q_full,
    output logic                                cmd_valid,
    output ipu_pkg::pix_cmd_t                   cmd,
    output logic [$clog2(MAX_SCALE+1)-1:0]      eff_scale
);

    localparam int SW = $clog2(MAX_SCALE + 1);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic [ipu_pkg::PIX_W-1:0] store_mem [MAX_WIDTH];
    logic [ipu_pkg::PIX_W-1:0] rd_data_reg;

    logic [CW-1:0] col_reg;
    logic [KW-1:0] copies_reg;
    logic          replaying_reg;

    logic                      s1_valid_reg;
    logic [ipu_pkg::PIX_W-1:0] s1_pixel_reg;
    logic                      s1_at_end_reg;
    logic [1:0]                s1_pad_reg;
    logic                      s1_drop_reg;
    logic                      s1_from_store_reg;

    logic [WW-1:0] eff_width;
    logic [31:0]   w32;
    logic [31:0]   s32;
    logic [31:0]   col_plus;
    logic          at_end;
    logic [1:0]    pad;
    logic          accept;
    logic          drop;

    always_comb
    begin
        if (scale_cfg == '0)
        begin
            eff_scale = SW'(1);
        end
        else if (32'(scale_cfg) > MAX_SCALE)
        begin
            eff_scale = SW'(MAX_SCALE);
        end
        else
        begin
            eff_scale = SW'(scale_cfg);
        end

        if (width_cfg == '0)
        begin
            eff_width = WW'(1);
        end
        else if (32'(width_cfg) > MAX_WIDTH)
        begin
            eff_width = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_width = WW'(width_cfg);
        end
    end

    // Padding is (w*s) mod 4, since -3 equals 1 modulo 4.
    assign w32      = 32'(eff_width);
    assign s32      = 32'(eff_scale);
    assign pad      = 2'(w32[1:0] * s32[1:0]);
    assign col_plus = 32'(col_reg) + 32'd1;
    assign at_end   = (col_plus >= w32);

    assign s_tready = !s1_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign drop     = (s_tuser != replaying_reg);

    always_ff @(posedge clk)
    begin
        if (accept && !drop && (s_tuser == ipu_pkg::OP_PUSH))
        begin
            store_mem[col_reg] <= s_tdata[ipu_pkg::PIX_W-1:0];
        end
        if (accept && !drop && (s_tuser == ipu_pkg::OP_REPLAY))
        begin
            rd_data_reg <= store_mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            copies_reg    <= '0;
            replaying_reg <= 1'b0;
        end
        else if (accept && !drop)
        begin
            if (!at_end)
            begin
                col_reg <= CW'(col_plus);
            end
            else
            begin
                col_reg <= '0;
                if (s_tuser == ipu_pkg::OP_PUSH)
                begin
                    if (eff_scale > SW'(1))
                    begin
                        copies_reg    <= KW'(eff_scale - SW'(1));
                        replaying_reg <= 1'b1;
                    end
                end
                else
                begin
                    if (copies_reg != '0)
                    begin
                        copies_reg <= copies_reg - KW'(1);
                    end
                    if (copies_reg <= KW'(1))
                    begin
                        replaying_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg      <= drop ? '0 : s_tdata[ipu_pkg::PIX_W-1:0];
            s1_at_end_reg     <= at_end && !drop;
            s1_pad_reg        <= (at_end && !drop) ? pad : 2'd0;
            s1_drop_reg       <= drop;
            s1_from_store_reg <= !drop && (s_tuser == ipu_pkg::OP_REPLAY);
        end
    end

    assign cmd_valid  = s1_valid_reg;
    assign cmd.pixel  = s1_from_store_reg ? rd_data_reg : s1_pixel_reg;
    assign cmd.at_end = s1_at_end_reg;
    assign cmd.pad    = s1_pad_reg;
    assign cmd.drop   = s1_drop_reg;

endmodule

@@ rtl/core/ipu_queue.sv @@
// Short command queue between the front and the back end of the upscaler.
// Depends on ipu_pkg.
module ipu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipu_pkg::pix_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output ipu_pkg::pix_cmd_t pop_data,
    output logic              empty
);

    ipu_pkg::pix_cmd_t            entry_reg [ipu_pkg::QUEUE_DEPTH];
    logic [ipu_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ipu_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ipu_pkg::QPTR_W:0]     count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign full     = (count_reg == (ipu_pkg::QPTR_W+1)'(ipu_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ipu_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ipu_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (ipu_pkg::QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (ipu_pkg::QPTR_W+1)'(1);
            end
        end
    end

endmodule

@@ rtl/core/ipu_back.sv @@
// Back end of the upscaler: repeats each queued pixel scale times (a dropped item once) and holds
// the result in the output register. Depends on ipu_pkg.
module ipu_back #(
    parameter int MAX_SCALE = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  ipu_pkg::pix_cmd_t                   q_data,
    output logic                                q_pop,
    input  logic [$clog2(MAX_SCALE+1)-1:0]      eff_scale,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ipu_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int SW = $clog2(MAX_SCALE + 1);

    logic [SW-1:0]                   rep_cnt_reg;
    logic [SW-1:0]                   rep_cnt_next;
    logic                            valid_reg;
    logic                            valid_next;
    logic [ipu_pkg::OUT_DATA_W-1:0]  data_reg;
    logic                            last_reg;
    logic                            drop_reg;
    logic [SW-1:0]                   n_copies;
    logic                            load;
    logic                            last_copy;
    logic                            mark_end;

    assign n_copies  = q_data.drop ? SW'(1) : eff_scale;
    assign load      = !q_empty && (!valid_reg || m_tready);
    assign last_copy = ((32'(rep_cnt_reg) + 32'd1) == 32'(n_copies));
    assign mark_end  = last_copy && q_data.at_end;
    assign q_pop     = load && last_copy;

    always_comb
    begin
        rep_cnt_next = rep_cnt_reg;
        valid_next   = valid_reg;
        if (load)
        begin
            rep_cnt_next = last_copy ? '0 : rep_cnt_reg + SW'(1);
            valid_next   = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rep_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            rep_cnt_reg <= rep_cnt_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {5'd0, (mark_end ? q_data.pad : 2'd0), mark_end, q_data.pixel};
            last_reg <= last_copy;
            drop_reg <= q_data.drop;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = drop_reg;

endmodule

@@ bench/integer_pixel_upscaler_check.sv @@
// Scoreboard for the integer pixel upscaler: it watches the configuration, input and
// output channels, predicts every output pixel and compares it with what the block sends.
// Depends on ipu_pkg for the opcode and register codes.
module upscale_checker #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_SCALE = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [ipu_pkg::WIDTH_CFG_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [ipu_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ipu_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            m_tlast,
    input  logic                            m_tuser,
    output int                              results_pending,
    output int                              failures
);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       run_last;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       dropped;
    } upscaled_pixel_t;

    upscaled_pixel_t                     expected_pixels[$];
    logic [ipu_pkg::PIX_W-1:0]           line_store[MAX_WIDTH];
    logic [11:0]                         column;
    logic [4:0]                          copies_left;
    logic                                replaying;
    logic [ipu_pkg::SCALE_CFG_W-1:0]     scale_reg;
    logic [ipu_pkg::WIDTH_CFG_W-1:0]     width_reg;
    int                                  fail_total;

    function automatic string describe(upscaled_pixel_t p);
        return $sformatf("b=%h g=%h r=%h last=%b end=%b pad=%0d drop=%b",
                         p.blue, p.green, p.red, p.run_last, p.row_end,
                         p.pad_bytes, p.dropped);
    endfunction

    task automatic predict_upscale(input logic op, input logic [ipu_pkg::PIX_W-1:0] pixel);
        int                        s;
        int                        w;
        int                        pad;
        logic                      at_end;
        logic [ipu_pkg::PIX_W-1:0] src;
        upscaled_pixel_t           r;
        s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg));
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        pad = (4 - ((w * s * 3) % 4)) % 4;
        at_end = (int'(column) + 1 >= w);
        if ((op == ipu_pkg::OP_REPLAY) != replaying)
        begin
            r = '0;
            r.run_last = 1'b1;
            r.dropped = 1'b1;
            expected_pixels.push_back(r);
            return;
        end
        if (op == ipu_pkg::OP_PUSH)
        begin
            line_store[column] = pixel;
            src = pixel;
        end
        else
        begin
            src = line_store[column];
        end
        for (int n = 0; n < s; n++)
        begin
            r.blue = src[7:0];
            r.green = src[15:8];
            r.red = src[23:16];
            r.run_last = (n == s - 1);
            r.row_end = at_end && (n == s - 1);
            r.pad_bytes = r.row_end ? pad[1:0] : 2'd0;
            r.dropped = 1'b0;
            expected_pixels.push_back(r);
        end
        if (at_end)
        begin
            column = '0;
            if (op == ipu_pkg::OP_PUSH)
            begin
                if (s > 1)
                begin
                    copies_left = 5'(s - 1);
                    replaying = 1'b1;
                end
            end
            else
            begin
                if (copies_left > 0)
                    copies_left = copies_left - 5'd1;
                if (copies_left == 0)
                    replaying = 1'b0;
            end
        end
        else
        begin
            column = column + 12'd1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        upscaled_pixel_t got;
        upscaled_pixel_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            column = '0;
            copies_left = '0;
            replaying = 1'b0;
            scale_reg = 5'd1;
            width_reg = 13'd1;
            fail_total = 0;
            results_pending <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == ipu_pkg::REG_SCALE)
                    scale_reg = cfg_data[ipu_pkg::SCALE_CFG_W-1:0];
                else
                    width_reg = cfg_data;
            end
            if (m_tvalid && m_tready)
            begin
                got.blue = m_tdata[7:0];
                got.green = m_tdata[15:8];
                got.red = m_tdata[23:16];
                got.row_end = m_tdata[24];
                got.pad_bytes = m_tdata[26:25];
                got.run_last = m_tlast;
                got.dropped = m_tuser;
                if (expected_pixels.size() == 0)
                begin
                    if (fail_total < 10)
                        $display("%0t: result with nothing expected: %s", $realtime,
                                 describe(got));
                    fail_total++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.blue !== want.blue || got.green !== want.green ||
                        got.red !== want.red || got.run_last !== want.run_last ||
                        got.row_end !== want.row_end || got.pad_bytes !== want.pad_bytes ||
                        got.dropped !== want.dropped)
                    begin
                        if (fail_total < 10)
                            $display("%0t: mismatch, expected %s, got %s", $realtime,
                                     describe(want), describe(got));
                        fail_total++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_upscale(s_tuser, s_tdata);
            results_pending <= expected_pixels.size();
            failures <= fail_total;
        end
    end

endmodule

@@ bench/integer_pixel_upscaler_tb.sv @@
// Top of the upscaler testbench: clock, reset, configuration and pixel stimulus with
// random stalls on both sides. Depends on ipu_pkg, integer_pixel_upscaler, upscale_checker.
module integer_pixel_upscaler_tb;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ipu_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                            s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ipu_pkg::OUT_DATA_W-1:0]  m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic                            cfg_index;
    logic [ipu_pkg::WIDTH_CFG_W-1:0] cfg_data;
    int                              results_pending;
    int                              failures;
    logic                            idling_on;
    int                              sent_items;
    int                              reps;
    int                              scale_val;
    int                              width_val;
    int                              copies;

    integer_pixel_upscaler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    upscale_checker CHK (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .results_pending (results_pending),
        .failures        (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #6000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_item(input logic op, input logic [ipu_pkg::IN_DATA_W-1:0] pixel);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pixel;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent_items++;
    endtask

    task automatic maybe_noise(input logic wrong_op);
        if ($urandom_range(0, 9) == 0)
            send_item(wrong_op, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input logic [ipu_pkg::SCALE_CFG_W-1:0] scale_cfg,
                             input logic [ipu_pkg::WIDTH_CFG_W-1:0] width_cfg);
        cfg_valid <= 1'b1;
        cfg_index <= ipu_pkg::REG_SCALE;
        cfg_data <= ipu_pkg::WIDTH_CFG_W'(scale_cfg);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= ipu_pkg::REG_ROW_WIDTH;
        cfg_data <= width_cfg;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= ipu_pkg::OP_PUSH;
        cfg_valid <= 1'b0;
        cfg_index <= ipu_pkg::REG_SCALE;
        cfg_data <= '0;
        idling_on = 1'b1;
        sent_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: a replay tick while collecting is dropped, then a one-pixel row.
        send_item(ipu_pkg::OP_REPLAY, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        send_item(ipu_pkg::OP_PUSH, 24'hFFFFFF);
        drain_results();
        configure(5'd0, 13'd0);
        send_item(ipu_pkg::OP_PUSH, 24'h000000);
        drain_results();

        // Oversized scale and width, then the width shrinks mid-row and ends it.
        configure(5'd31, 13'h1FFF);
        send_item(ipu_pkg::OP_PUSH, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        send_item(ipu_pkg::OP_PUSH, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        drain_results();
        configure(5'd31, 13'd0);
        send_item(ipu_pkg::OP_PUSH, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        send_item(ipu_pkg::OP_PUSH, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        repeat (15)
            send_item(ipu_pkg::OP_REPLAY, ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));

        while (sent_items < 250)
        begin
            drain_results();
            idling_on = (sent_items < 220) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 7) == 0)
            begin
                width_val = $urandom_range(7, 24);
                scale_val = $urandom_range(0, 2);
            end
            else
            begin
                scale_val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(1, 4);
                width_val = (scale_val > 4) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            end
            configure(scale_val[4:0], width_val[12:0]);
            copies = (scale_val == 0) ? 1 : ((scale_val > 16) ? 16 : scale_val);
            reps = $urandom_range(1, 3);
            for (int rep = 0; rep < reps && sent_items < 250; rep++)
            begin
                for (int c = 0; c < width_val; c++)
                begin
                    maybe_noise(ipu_pkg::OP_REPLAY);
                    send_item(ipu_pkg::OP_PUSH,
                              ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                end
                for (int k = 1; k < copies; k++)
                begin
                    for (int c = 0; c < width_val; c++)
                    begin
                        maybe_noise(ipu_pkg::OP_PUSH);
                        send_item(ipu_pkg::OP_REPLAY,
                                  ipu_pkg::IN_DATA_W'($urandom_range(0, 24'hFFFFFF)));
                    end
                end
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (failures == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
